// ===== src/wcrp_pkg.sv =====
// Shared types, command codes and constant tables for the wireframe cube core.
// Used by wcrp_ctrl, wcrp_dpath and the top level; no dependencies.
package wcrp_pkg;

    localparam logic [3:0] CMD_NOP    = 4'd0;
    localparam logic [3:0] CMD_LOAD   = 4'd1;
    localparam logic [3:0] CMD_CINIT  = 4'd2;
    localparam logic [3:0] CMD_CSTEP  = 4'd3;
    localparam logic [3:0] CMD_CSTORE = 4'd4;
    localparam logic [3:0] CMD_KINIT  = 4'd5;
    localparam logic [3:0] CMD_MULA   = 4'd6;
    localparam logic [3:0] CMD_MULB   = 4'd7;
    localparam logic [3:0] CMD_MWR    = 4'd8;
    localparam logic [3:0] CMD_PMUL   = 4'd9;
    localparam logic [3:0] CMD_PNUM   = 4'd10;
    localparam logic [3:0] CMD_DINIT  = 4'd11;
    localparam logic [3:0] CMD_DSTEP  = 4'd12;
    localparam logic [3:0] CMD_DWR    = 4'd13;
    localparam logic [3:0] CMD_ERD    = 4'd14;
    localparam logic [3:0] CMD_EOUT   = 4'd15;

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_PDIST  = 2'd1;
    localparam logic [1:0] REG_CX     = 2'd2;
    localparam logic [1:0] REG_CY     = 2'd3;

    localparam logic [5:0] SCALE_RST  = 6'd16;
    localparam logic [5:0] PDIST_RST  = 6'd4;
    localparam logic [7:0] CX_RST     = 8'd64;
    localparam logic [7:0] CY_RST     = 8'd32;

    localparam logic [3:0] CORDIC_LAST = 4'd14;
    localparam logic [3:0] DIV_LAST    = 4'd15;
    localparam logic [3:0] EDGE_LAST   = 4'd11;
    localparam logic [1:0] AXIS_LAST   = 2'd2;
    localparam logic [2:0] CORNER_LAST = 3'd7;
    localparam logic [2:0] MOP_LAST    = 3'd5;

    localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] axis;
        logic [3:0] step;
        logic [2:0] corner;
        logic [2:0] mop;
        logic       ycoord;
        logic [3:0] edge_idx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [5:0] scale;
        logic [5:0] persp_dist;
        logic [7:0] center_x;
        logic [7:0] center_y;
    } t_cfg;

    function automatic logic [13:0] atan_q(input logic [3:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] edge_a(input logic [3:0] e);
        logic [2:0] v;
        unique case (e)
            4'd0, 4'd1, 4'd2: v = 3'd0;
            4'd3, 4'd4:       v = 3'd1;
            4'd5, 4'd6:       v = 3'd2;
            4'd7:             v = 3'd3;
            4'd8, 4'd9:       v = 3'd4;
            4'd10:            v = 3'd5;
            4'd11:            v = 3'd6;
            default:          v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] edge_b(input logic [3:0] e);
        logic [2:0] v;
        unique case (e)
            4'd0:                v = 3'd1;
            4'd1:                v = 3'd2;
            4'd2:                v = 3'd4;
            4'd3, 4'd5:          v = 3'd3;
            4'd4, 4'd8:          v = 3'd5;
            4'd6, 4'd9:          v = 3'd6;
            4'd7, 4'd10, 4'd11:  v = 3'd7;
            default:             v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/wcrp_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module wcrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== src/wcrp_ctrl.sv =====
// Sequencer for the cube core: steps CORDIC, rotation, projection and edge output.
// Depends on wcrp_pkg; drives wcrp_dpath through a command struct.
module wcrp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wcrp_pkg::t_stat i_stat,
    output wcrp_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CINIT  = 4'd1;
    localparam logic [3:0] S_CSTEP  = 4'd2;
    localparam logic [3:0] S_CSTORE = 4'd3;
    localparam logic [3:0] S_KINIT  = 4'd4;
    localparam logic [3:0] S_MULA   = 4'd5;
    localparam logic [3:0] S_MULB   = 4'd6;
    localparam logic [3:0] S_MWR    = 4'd7;
    localparam logic [3:0] S_PMUL   = 4'd8;
    localparam logic [3:0] S_PNUM   = 4'd9;
    localparam logic [3:0] S_DINIT  = 4'd10;
    localparam logic [3:0] S_DSTEP  = 4'd11;
    localparam logic [3:0] S_DWR    = 4'd12;
    localparam logic [3:0] S_ERD    = 4'd13;
    localparam logic [3:0] S_EOUT   = 4'd14;

    logic [3:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [3:0] r_step, n_step;
    logic [2:0] r_corner, n_corner;
    logic [2:0] r_mop, n_mop;
    logic       r_ycoord, n_ycoord;
    logic [3:0] r_edge, n_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_step   <= '0;
            r_corner <= '0;
            r_mop    <= '0;
            r_ycoord <= 1'b0;
            r_edge   <= '0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_step   <= n_step;
            r_corner <= n_corner;
            r_mop    <= n_mop;
            r_ycoord <= n_ycoord;
            r_edge   <= n_edge;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_step   = r_step;
        n_corner = r_corner;
        n_mop    = r_mop;
        n_ycoord = r_ycoord;
        n_edge   = r_edge;
        o_cmd.op = wcrp_pkg::CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = wcrp_pkg::CMD_LOAD;
                    n_axis   = '0;
                    n_state  = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.op = wcrp_pkg::CMD_CINIT;
                n_step   = '0;
                n_state  = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.op = wcrp_pkg::CMD_CSTEP;
                if (r_step == wcrp_pkg::CORDIC_LAST) begin
                    n_state = S_CSTORE;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_CSTORE: begin
                o_cmd.op = wcrp_pkg::CMD_CSTORE;
                if (r_axis == wcrp_pkg::AXIS_LAST) begin
                    n_corner = '0;
                    n_state  = S_KINIT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_CINIT;
                end
            end
            S_KINIT: begin
                o_cmd.op = wcrp_pkg::CMD_KINIT;
                n_mop    = '0;
                n_state  = S_MULA;
            end
            S_MULA: begin
                o_cmd.op = wcrp_pkg::CMD_MULA;
                n_state  = S_MULB;
            end
            S_MULB: begin
                o_cmd.op = wcrp_pkg::CMD_MULB;
                n_state  = S_MWR;
            end
            S_MWR: begin
                o_cmd.op = wcrp_pkg::CMD_MWR;
                if (r_mop == wcrp_pkg::MOP_LAST) begin
                    n_ycoord = 1'b0;
                    n_state  = S_PMUL;
                end else begin
                    n_mop   = r_mop + 3'd1;
                    n_state = S_MULA;
                end
            end
            S_PMUL: begin
                o_cmd.op = wcrp_pkg::CMD_PMUL;
                n_state  = S_PNUM;
            end
            S_PNUM: begin
                o_cmd.op = wcrp_pkg::CMD_PNUM;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = wcrp_pkg::CMD_DINIT;
                n_step   = '0;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = wcrp_pkg::CMD_DSTEP;
                if (r_step == wcrp_pkg::DIV_LAST) begin
                    n_state = S_DWR;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_DWR: begin
                o_cmd.op = wcrp_pkg::CMD_DWR;
                if (!r_ycoord) begin
                    n_ycoord = 1'b1;
                    n_state  = S_PMUL;
                end else if (r_corner == wcrp_pkg::CORNER_LAST) begin
                    n_edge  = '0;
                    n_state = S_ERD;
                end else begin
                    n_corner = r_corner + 3'd1;
                    n_state  = S_KINIT;
                end
            end
            S_ERD: begin
                o_cmd.op = wcrp_pkg::CMD_ERD;
                n_state  = S_EOUT;
            end
            S_EOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = wcrp_pkg::CMD_EOUT;
                    if (r_edge == wcrp_pkg::EDGE_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_edge  = r_edge + 4'd1;
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.axis     = r_axis;
    assign o_cmd.step     = r_step;
    assign o_cmd.corner   = r_corner;
    assign o_cmd.mop      = r_mop;
    assign o_cmd.ycoord   = r_ycoord;
    assign o_cmd.edge_idx = r_edge;
    assign o_busy         = (r_state != S_IDLE);
endmodule

// ===== src/wcrp_dpath.sv =====
// Datapath: shared CORDIC, multiply-accumulate rotation logic, serial divider,
// corner store and output register. Depends on wcrp_pkg and wcrp_ram.
module wcrp_dpath #(
    parameter int ANGLE_WIDTH = 16,
    parameter int COORD_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wcrp_pkg::t_cmd                i_cmd,
    input  wcrp_pkg::t_cfg                i_cfg,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_x,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_y,
    input  logic [ANGLE_WIDTH-1:0]        i_angle_z,
    input  logic                          i_stall,
    output wcrp_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [3:0]                    o_edge_index,
    output logic signed [COORD_WIDTH-1:0] o_start_x,
    output logic signed [COORD_WIDTH-1:0] o_start_y,
    output logic signed [COORD_WIDTH-1:0] o_end_x,
    output logic signed [COORD_WIDTH-1:0] o_end_y,
    output logic                          o_last_edge
);
    localparam int CW = COORD_WIDTH;
    localparam logic signed [17:0] SAT_HI = 18'sd1 <<< (CW - 1);
    localparam logic signed [17:0] SAT_LO = -(18'sd1 <<< (CW - 1));

    logic [ANGLE_WIDTH-1:0] r_ang [3];
    logic signed [17:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_quad;
    logic signed [17:0] r_cos [3];
    logic signed [17:0] r_sin [3];
    logic signed [17:0] r_x, r_y, r_z, r_t;
    logic signed [35:0] r_prod;
    logic signed [36:0] r_acc;
    logic signed [24:0] r_m;
    logic signed [31:0] r_num;
    logic [20:0]        r_den;
    logic [31:0]        r_rem;
    logic [35:0]        r_dsh;
    logic [15:0]        r_quo;
    logic               r_neg;
    logic [CW-1:0]      r_px;

    logic [ANGLE_WIDTH+15:0] w_wide;
    logic [15:0]        w_ph;
    logic signed [17:0] w_dx, w_dy, w_atan;
    logic signed [17:0] w_a, w_p, w_b, w_q;
    logic signed [35:0] w_prod_b;
    logic signed [31:0] w_num;
    logic signed [36:0] w_accr;
    logic signed [17:0] w_res;
    logic [5:0]         w_d;
    logic signed [17:0] w_coord;
    logic signed [21:0] w_den;
    logic               w_ge;
    logic signed [16:0] w_qs;
    logic signed [17:0] w_pos;
    logic [CW-1:0]      w_sat;
    logic [2*CW-1:0]    w_rd_a, w_rd_b;
    logic               w_we;

    assign w_wide = {r_ang[i_cmd.axis], 16'b0};
    assign w_ph   = w_wide[ANGLE_WIDTH+15 -: 16];

    assign w_dx   = r_cx >>> i_cmd.step;
    assign w_dy   = r_cy >>> i_cmd.step;
    assign w_atan = $signed({4'b0, wcrp_pkg::atan_q(i_cmd.step)});

    always_comb begin
        unique case (i_cmd.mop)
            3'd0: begin w_a = r_y; w_p = r_cos[0];  w_b = r_z; w_q = -r_sin[0]; end
            3'd1: begin w_a = r_y; w_p = r_sin[0];  w_b = r_z; w_q = r_cos[0];  end
            3'd2: begin w_a = r_x; w_p = r_cos[1];  w_b = r_z; w_q = r_sin[1];  end
            3'd3: begin w_a = r_x; w_p = -r_sin[1]; w_b = r_z; w_q = r_cos[1];  end
            3'd4: begin w_a = r_x; w_p = r_cos[2];  w_b = r_y; w_q = r_sin[2];  end
            3'd5: begin w_a = r_x; w_p = -r_sin[2]; w_b = r_y; w_q = r_cos[2];  end
            default: begin w_a = r_x; w_p = r_cos[0]; w_b = r_y; w_q = r_sin[0]; end
        endcase
    end

    assign w_prod_b = w_b * w_q;
    assign w_num    = r_m * $signed({1'b0, i_cfg.scale});

    assign w_accr  = r_acc + (r_acc[36] ? 37'sd16383 : 37'sd0);
    assign w_res   = 18'(w_accr >>> 14);

    assign w_d     = (i_cfg.persp_dist < 6'd2) ? 6'd2 : i_cfg.persp_dist;
    assign w_coord = i_cmd.ycoord ? r_y : r_x;
    assign w_den   = $signed({2'b0, w_d, 14'b0}) + 22'(r_z);

    assign w_ge    = ({4'b0, r_rem} >= r_dsh);
    assign w_qs    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_pos   = (i_cmd.ycoord ? $signed({10'b0, i_cfg.center_y})
                                   : $signed({10'b0, i_cfg.center_x})) + 18'(w_qs);

    always_comb begin
        if (w_pos >= SAT_HI) begin
            w_sat = CW'(SAT_HI - 18'sd1);
        end else if (w_pos < SAT_LO) begin
            w_sat = CW'(SAT_LO);
        end else begin
            w_sat = CW'(w_pos);
        end
    end

    assign w_we = (i_cmd.op == wcrp_pkg::CMD_DWR) && i_cmd.ycoord;

    wcrp_ram #(
        .WIDTH(2 * CW),
        .DEPTH(8)
    ) u_corner_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (i_cmd.corner),
        .i_wdata  ({r_px, w_sat}),
        .i_raddr_a(wcrp_pkg::edge_a(i_cmd.edge_idx)),
        .i_raddr_b(wcrp_pkg::edge_b(i_cmd.edge_idx)),
        .o_rdata_a(w_rd_a),
        .o_rdata_b(w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            wcrp_pkg::CMD_LOAD: begin
                r_ang[0] <= i_angle_x;
                r_ang[1] <= i_angle_y;
                r_ang[2] <= i_angle_z;
            end
            wcrp_pkg::CMD_CINIT: begin
                r_cx   <= wcrp_pkg::CORDIC_GAIN;
                r_cy   <= '0;
                r_cz   <= $signed({4'b0, w_ph[13:0]});
                r_quad <= w_ph[15:14];
            end
            wcrp_pkg::CMD_CSTEP: begin
                if (!r_cz[17]) begin
                    r_cx <= r_cx - w_dy;
                    r_cy <= r_cy + w_dx;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_dy;
                    r_cy <= r_cy - w_dx;
                    r_cz <= r_cz + w_atan;
                end
            end
            wcrp_pkg::CMD_CSTORE: begin
                unique case (r_quad)
                    2'd0: begin r_cos[i_cmd.axis] <= r_cx;  r_sin[i_cmd.axis] <= r_cy;  end
                    2'd1: begin r_cos[i_cmd.axis] <= -r_cy; r_sin[i_cmd.axis] <= r_cx;  end
                    2'd2: begin r_cos[i_cmd.axis] <= -r_cx; r_sin[i_cmd.axis] <= -r_cy; end
                    default: begin
                        r_cos[i_cmd.axis] <= r_cy;
                        r_sin[i_cmd.axis] <= -r_cx;
                    end
                endcase
            end
            wcrp_pkg::CMD_KINIT: begin
                r_x <= i_cmd.corner[2] ? -18'sd16384 : 18'sd16384;
                r_y <= i_cmd.corner[1] ? -18'sd16384 : 18'sd16384;
                r_z <= i_cmd.corner[0] ? -18'sd16384 : 18'sd16384;
            end
            wcrp_pkg::CMD_MULA: r_prod <= w_a * w_p;
            wcrp_pkg::CMD_MULB: r_acc  <= 37'(r_prod) + 37'(w_prod_b);
            wcrp_pkg::CMD_MWR: begin
                unique case (i_cmd.mop)
                    3'd1: begin r_z <= w_res; r_y <= r_t; end
                    3'd3: begin r_z <= w_res; r_x <= r_t; end
                    3'd5: begin r_y <= w_res; r_x <= r_t; end
                    default: r_t <= w_res;
                endcase
            end
            wcrp_pkg::CMD_PMUL: r_m <= w_coord * $signed({1'b0, w_d});
            wcrp_pkg::CMD_PNUM: begin
                r_num <= w_num;
                r_den <= 21'(w_den);
            end
            wcrp_pkg::CMD_DINIT: begin
                r_rem <= r_num[31] ? 32'(-r_num) : 32'(r_num);
                r_neg <= r_num[31];
                r_dsh <= {r_den, 15'b0};
                r_quo <= '0;
            end
            wcrp_pkg::CMD_DSTEP: begin
                if (w_ge) begin
                    r_rem <= 32'({4'b0, r_rem} - r_dsh);
                end
                r_quo <= {r_quo[14:0], w_ge};
                r_dsh <= r_dsh >> 1;
            end
            wcrp_pkg::CMD_DWR: begin
                if (!i_cmd.ycoord) begin
                    r_px <= w_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.op == wcrp_pkg::CMD_EOUT) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == wcrp_pkg::CMD_EOUT) begin
            o_edge_index <= i_cmd.edge_idx;
            o_start_x    <= w_rd_a[2*CW-1:CW];
            o_start_y    <= w_rd_a[CW-1:0];
            o_end_x      <= w_rd_b[2*CW-1:CW];
            o_end_y      <= w_rd_b[CW-1:0];
            o_last_edge  <= (i_cmd.edge_idx == wcrp_pkg::EDGE_LAST);
        end
    end

    assign o_stat.out_free = !o_valid || !i_stall;
endmodule

// ===== src/wireframe_cube_rotate_project_core.sv =====
// A frame runs the 15-step CORDIC three times, rotates each corner with multiply-accumulate
// steps and projects its x and y coordinates through the serial divider. No new frame is
// accepted (o_stall stays high) until the last edge item has been issued to the output.
// Edge items follow, one for each cube edge, each read from the corner store and issued when the output is free.
// Reset (synchronous, active low) idles the sequencer, drops o_valid and loads
// the configuration registers with their default values.
module wireframe_cube_rotate_project_core #(
    parameter int ANGLE_WIDTH = 16,
    parameter int COORD_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_x,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_y,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [3:0]                    o_edge_index,
    output logic signed [COORD_WIDTH-1:0] o_start_x,
    output logic signed [COORD_WIDTH-1:0] o_start_y,
    output logic signed [COORD_WIDTH-1:0] o_end_x,
    output logic signed [COORD_WIDTH-1:0] o_end_y,
    output logic                          o_last_edge,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    wcrp_pkg::t_cfg  r_cfg;
    wcrp_pkg::t_cmd  w_cmd;
    wcrp_pkg::t_stat w_stat;
    logic            w_busy;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale      <= wcrp_pkg::SCALE_RST;
            r_cfg.persp_dist <= wcrp_pkg::PDIST_RST;
            r_cfg.center_x   <= wcrp_pkg::CX_RST;
            r_cfg.center_y   <= wcrp_pkg::CY_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                wcrp_pkg::REG_SCALE: r_cfg.scale      <= pwdata[5:0];
                wcrp_pkg::REG_PDIST: r_cfg.persp_dist <= pwdata[5:0];
                wcrp_pkg::REG_CX:    r_cfg.center_x   <= pwdata[7:0];
                wcrp_pkg::REG_CY:    r_cfg.center_y   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wcrp_pkg::REG_SCALE: prdata = {26'b0, r_cfg.scale};
            wcrp_pkg::REG_PDIST: prdata = {26'b0, r_cfg.persp_dist};
            wcrp_pkg::REG_CX:    prdata = {24'b0, r_cfg.center_x};
            default:             prdata = {24'b0, r_cfg.center_y};
        endcase
    end

    wcrp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_busy (w_busy)
    );

    wcrp_dpath #(
        .ANGLE_WIDTH(ANGLE_WIDTH),
        .COORD_WIDTH(COORD_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_angle_x   (i_angle_x),
        .i_angle_y   (i_angle_y),
        .i_angle_z   (i_angle_z),
        .i_stall     (i_stall),
        .o_stat      (w_stat),
        .o_valid     (o_valid),
        .o_edge_index(o_edge_index),
        .o_start_x   (o_start_x),
        .o_start_y   (o_start_y),
        .o_end_x     (o_end_x),
        .o_end_y     (o_end_y),
        .o_last_edge (o_last_edge)
    );

    assign o_stall = w_busy;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("core not busy after frame accept");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_edge == (o_edge_index == wcrp_pkg::EDGE_LAST)))
        else $error("last_edge flag disagrees with edge index");

    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_edge_index <= wcrp_pkg::EDGE_LAST)
        else $error("edge index out of range");
`endif
endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the wireframe cube rotate/project core: drives angle frames
// and APB register writes, predicts an edge item for each cube edge of every frame and checks them.
// Depends on wcrp_pkg and wireframe_cube_rotate_project_core.
`timescale 1ns / 1ps

class edge_scoreboard;
    typedef struct packed {
        logic [3:0]         idx;
        logic signed [11:0] sx, sy, ex, ey;
        logic               last;
    } t_edge_item;

    t_edge_item pending[$];
    int errors;
    int scale_r, dist_r, cx_r, cy_r;

    function new();
        errors = 0;
        scale_r = 16;
        dist_r = 4;
        cx_r = 64;
        cy_r = 32;
    endfunction

    function void set_reg(int idx, int val);
        case (idx)
            wcrp_pkg::REG_SCALE: scale_r = val & 63;
            wcrp_pkg::REG_PDIST: dist_r = val & 63;
            wcrp_pkg::REG_CX:    cx_r = val & 255;
            wcrp_pkg::REG_CY:    cy_r = val & 255;
            default: ;
        endcase
    endfunction

    static function int floor_shr(int v, int s);
        return v >>> s;
    endfunction

    static function void sin_cos(logic [15:0] ph, output int c, output int s);
        int x, y, z, dx, dy;
        int at[15];
        at = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        x = 9949;
        y = 0;
        z = int'(ph[13:0]);
        for (int i = 0; i < 15; i++) begin
            dx = floor_shr(x, i);
            dy = floor_shr(y, i);
            if (z >= 0) begin
                x -= dy; y += dx; z -= at[i];
            end else begin
                x += dy; y -= dx; z += at[i];
            end
        end
        case (ph[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    static function int mac14(longint a, longint p, longint b, longint q);
        return int'((a * p + b * q) / 16384);
    endfunction

    static function logic signed [11:0] clip(longint v);
        if (v > 2047) return 12'sd2047;
        if (v < -2048) return -12'sd2048;
        return v[11:0];
    endfunction

    function void note_frame(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        int cx, sx, cy, sy, cz, sz, x, y, z, t, den;
        longint d;
        longint px[8], py[8];
        t_edge_item e;
        sin_cos(ax, cx, sx);
        sin_cos(ay, cy, sy);
        sin_cos(az, cz, sz);
        d = (dist_r < 2) ? 2 : dist_r;
        for (int k = 0; k < 8; k++) begin
            x = k[2] ? -16384 : 16384;
            y = k[1] ? -16384 : 16384;
            z = k[0] ? -16384 : 16384;
            t = mac14(y, cx, z, -sx); z = mac14(y, sx, z, cx); y = t;
            t = mac14(x, cy, z, sy); z = mac14(x, -sy, z, cy); x = t;
            t = mac14(x, cz, y, sz); y = mac14(x, -sz, y, cz); x = t;
            den = int'(d * 16384) + z;
            px[k] = longint'(cx_r) + (longint'(scale_r) * x * d) / den;
            py[k] = longint'(cy_r) + (longint'(scale_r) * y * d) / den;
        end
        for (int k = 0; k < 12; k++) begin
            e.idx = 4'(k);
            e.sx = clip(px[wcrp_pkg::edge_a(4'(k))]);
            e.sy = clip(py[wcrp_pkg::edge_a(4'(k))]);
            e.ex = clip(px[wcrp_pkg::edge_b(4'(k))]);
            e.ey = clip(py[wcrp_pkg::edge_b(4'(k))]);
            e.last = (k == 11);
            pending.push_back(e);
        end
    endfunction

    function void check_edge(t_edge_item got);
        t_edge_item w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected edge item idx=%0d", $time, got.idx);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.idx !== w.idx) begin
            $display("%0t: edge_index exp %0d got %0d", $time, w.idx, got.idx); errors++;
        end
        if (got.sx !== w.sx) begin
            $display("%0t: start_x exp %0d got %0d", $time, w.sx, got.sx); errors++;
        end
        if (got.sy !== w.sy) begin
            $display("%0t: start_y exp %0d got %0d", $time, w.sy, got.sy); errors++;
        end
        if (got.ex !== w.ex) begin
            $display("%0t: end_x exp %0d got %0d", $time, w.ex, got.ex); errors++;
        end
        if (got.ey !== w.ey) begin
            $display("%0t: end_y exp %0d got %0d", $time, w.ey, got.ey); errors++;
        end
        if (got.last !== w.last) begin
            $display("%0t: last_edge exp %0d got %0d", $time, w.last, got.last); errors++;
        end
    endfunction
endclass

module testbench;
    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_stall = 0;
    logic signed [15:0] ang_x = 0, ang_y = 0, ang_z = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    wire in_stall, out_valid, last_e, pready;
    wire [3:0] e_idx;
    wire signed [11:0] s_x, s_y, e_x, e_y;
    wire [31:0] prdata;

    int send_idle_pct = 0, recv_idle_pct = 0;
    int hold_cycles = 0;
    edge_scoreboard board;

    wireframe_cube_rotate_project_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_angle_x(ang_x), .i_angle_y(ang_y), .i_angle_z(ang_z),
        .o_valid(out_valid), .i_stall(out_stall), .o_edge_index(e_idx),
        .o_start_x(s_x), .o_start_y(s_y), .o_end_x(e_x), .o_end_y(e_y),
        .o_last_edge(last_e), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial board = new();

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_edge({e_idx, s_x, s_y, e_x, e_y, last_e});
    end

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input int idx, input int val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 4'(4 * idx); pwdata <= val;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, val);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_frame(input logic [15:0] ax, ay, az);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1; ang_x <= ax; ang_y <= ay; ang_z <= az;
        do @(posedge clk); while (in_stall);
        board.note_frame(ax, ay, az);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_frames(input int n);
        for (int i = 0; i < n; i++)
            send_frame(16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_frame(16'h0000, 16'h0000, 16'h0000);
        send_frame(16'h8000, 16'h7FFF, 16'hFFFF);
        send_frame(16'h4000, 16'hC000, 16'h2000);
        send_frame(16'h1234, 16'hA5A5, 16'h5A5A);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        write_reg(wcrp_pkg::REG_SCALE, 0);
        write_reg(wcrp_pkg::REG_PDIST, 0);
        write_reg(wcrp_pkg::REG_CX, 255);
        write_reg(wcrp_pkg::REG_CY, 0);
        send_frame(16'h2000, 16'h1000, 16'h0800);
        send_frame(16'h7FFF, 16'h8000, 16'h0001);
        drain();
        write_reg(wcrp_pkg::REG_SCALE, 63);
        write_reg(wcrp_pkg::REG_PDIST, 1);
        write_reg(wcrp_pkg::REG_CX, 0);
        write_reg(wcrp_pkg::REG_CY, 255);
        send_frame(16'h2000, 16'h2000, 16'h2000);
        send_frame(16'hE000, 16'h6000, 16'hA000);
        drain();
        write_reg(wcrp_pkg::REG_SCALE, 32'hFFFF_FFC1);
        write_reg(wcrp_pkg::REG_PDIST, 32'hFFFF_FF3F);
        write_reg(wcrp_pkg::REG_CX, 32'h0000_1280);
        write_reg(wcrp_pkg::REG_CY, 32'hABCD_EF80);
        send_frame(16'h0000, 16'h0000, 16'h0000);
        send_frame(16'h4000, 16'h4000, 16'h4000);
        drain();

        send_idle_pct = 19; recv_idle_pct = 52;
        write_reg(wcrp_pkg::REG_SCALE, 16); write_reg(wcrp_pkg::REG_PDIST, 4);
        write_reg(wcrp_pkg::REG_CX, 64); write_reg(wcrp_pkg::REG_CY, 32);
        random_frames(50);
        hold_cycles = 3000;
        random_frames(4);
        drain();

        send_idle_pct = 52; recv_idle_pct = 19;
        write_reg(wcrp_pkg::REG_SCALE, $urandom_range(63, 1));
        write_reg(wcrp_pkg::REG_PDIST, $urandom_range(63, 2));
        write_reg(wcrp_pkg::REG_CX, $urandom_range(255));
        write_reg(wcrp_pkg::REG_CY, $urandom_range(255));
        random_frames(50);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(wcrp_pkg::REG_SCALE, 63); write_reg(wcrp_pkg::REG_PDIST, 2);
        write_reg(wcrp_pkg::REG_CX, 128); write_reg(wcrp_pkg::REG_CY, 128);
        random_frames(45);
        drain();

        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== wireframe_cube_rotate_project_core.f =====
src/wcrp_pkg.sv
src/wcrp_ram.sv
src/wcrp_ctrl.sv
src/wcrp_dpath.sv
src/wireframe_cube_rotate_project_core.sv
tb/testbench.sv
